[design/mfsgd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and fixed-point helpers for the matrix factorization SGD block.
// No dependencies; mfsgd_ctrl, mfsgd_datapath and the top level import it.
package mfsgd_pkg;

    // Operation codes carried in the input item
    localparam logic [2:0] OP_TRAIN      = 3'd0;
    localparam logic [2:0] OP_WRITE_USER = 3'd1;
    localparam logic [2:0] OP_WRITE_ITEM = 3'd2;
    localparam logic [2:0] OP_READ_USER  = 3'd3;
    localparam logic [2:0] OP_READ_ITEM  = 3'd4;

    // Configuration register indexes
    localparam int          REG_ADDR_W        = 5;
    localparam logic [2:0]  REG_LEARN_RATE    = 3'd0;
    localparam logic [2:0]  REG_FACTOR_DECAY  = 3'd1;
    localparam logic [2:0]  REG_BIAS_DECAY    = 3'd2;
    localparam logic [2:0]  REG_DECAY_ENABLE  = 3'd3;
    localparam logic [2:0]  REG_BIAS_ENABLE   = 3'd4;

    localparam logic [15:0] LEARN_RATE_RESET  = 16'd655;

    // Wide signed intermediate, exact for every sum the datapath forms
    localparam int WIDE_W = 68;
    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam t_wide SAT_MAX = 68'sd2147483647;
    localparam t_wide SAT_MIN = -68'sd2147483648;
    localparam t_wide RND_HALF = 68'sd32768;

    typedef struct packed {
        logic        [2:0]  opcode;
        logic        [9:0]  user_index;
        logic        [9:0]  item_index;
        logic        [4:0]  factor_index;
        logic signed [31:0] rating_value;
        logic signed [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] residual;
        logic signed [31:0] read_data;
    } t_out_item;

    typedef struct packed {
        logic [15:0] learn_rate;
        logic [15:0] factor_decay;
        logic [15:0] bias_decay;
        logic        decay_enable;
        logic        bias_enable;
    } t_cfg;

    typedef enum logic [3:0] {
        MUL_UV,
        MUL_LR_E,
        MUL_LR_FD,
        MUL_LR_BD,
        MUL_G_VRAM,
        MUL_G_U,
        MUL_S_U,
        MUL_S_V,
        MUL_T_UB,
        MUL_T_IB
    } t_mul_sel;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_RESID,
        OUT_READ
    } t_out_sel;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_WRITE,
        ST_READ,
        ST_DOT,
        ST_RESID,
        ST_MUL_GAIN,
        ST_LOAD_GAIN,
        ST_LOAD_S,
        ST_LOAD_T,
        ST_U_MUL,
        ST_U_UPD,
        ST_V_MUL,
        ST_V_UPD,
        ST_UD_MUL,
        ST_UD_UPD,
        ST_VD_MUL,
        ST_VD_UPD,
        ST_ELEM_WR,
        ST_BIAS_G,
        ST_UBD_MUL,
        ST_UBD_UPD,
        ST_IBD_MUL,
        ST_IBD_UPD,
        ST_BIAS_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic     load;       // latch the accepted item
        logic     acc_clr;
        logic     dot_issue;
        logic     res_en;
        t_mul_sel mul_sel;
        logic     g_en;
        logic     s_en;
        logic     t_en;
        logic     uv_load;
        logic     u_upd;
        logic     v_upd;
        logic     fac_we;
        logic     bias_g;
        logic     ub_upd;
        logic     ib_upd;
        logic     bias_we;
        logic     op_we;
        logic     out_load;
        t_out_sel out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic is_train;
        logic is_write;
        logic is_read;
        logic target_ok;
    } t_dp_status;

    // floor((x + 2^15) / 2^16)
    function automatic t_wide rnd16(input logic signed [65:0] p);
        t_wide x;
        x = WIDE_W'(p) + RND_HALF;
        return x >>> 16;
    endfunction

    function automatic logic signed [31:0] sat32(input t_wide x);
        logic signed [31:0] r;
        if (x > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'(x);
        end
        return r;
    endfunction

endpackage

[design/mfsgd_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mfsgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/mfsgd_ctrl.sv]
`timescale 1ns / 1ps
// SGD block sequencer: steps each train item through dot product, gain
// computation, per-element row update and bias update. Uses mfsgd_pkg.
module mfsgd_ctrl #(
    parameter int FACTORS = 16,
    parameter int EW = (FACTORS > 1) ? $clog2(FACTORS) : 1,
    parameter int CW = $clog2(FACTORS + 2)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_decay_enable,
    input  mfsgd_pkg::t_dp_status i_status,
    output mfsgd_pkg::t_dp_cmd    o_cmd,
    output logic [EW-1:0]         o_rd_elem,
    output logic [EW-1:0]         o_wr_elem
);
    import mfsgd_pkg::*;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic [CW-1:0] cnt_inc;
    logic          out_free;
    logic          cnt_last;
    logic          dot_end;

    assign cnt_inc  = r_cnt + CW'(1);
    assign out_free = !r_out_valid || !i_out_stall;
    assign cnt_last = (r_cnt == CW'(FACTORS - 1));
    assign dot_end  = (r_cnt == CW'(FACTORS + 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_cnt = '0;
                if (!i_status.target_ok) begin
                    n_state = ST_DONE;
                end else if (i_status.is_train) begin
                    n_state = ST_DOT;
                end else if (i_status.is_write) begin
                    n_state = ST_WRITE;
                end else if (i_status.is_read) begin
                    n_state = ST_READ;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_WRITE:   n_state = ST_DONE;
            ST_READ:    n_state = ST_DONE;
            ST_DOT: begin
                n_cnt = cnt_inc;
                if (dot_end) begin
                    n_state = ST_RESID;
                end
            end
            ST_RESID: begin
                n_cnt   = '0;
                n_state = ST_MUL_GAIN;
            end
            ST_MUL_GAIN:  n_state = ST_LOAD_GAIN;
            ST_LOAD_GAIN: n_state = ST_LOAD_S;
            ST_LOAD_S:    n_state = ST_LOAD_T;
            ST_LOAD_T:    n_state = ST_U_MUL;
            ST_U_MUL:     n_state = ST_U_UPD;
            ST_U_UPD:     n_state = ST_V_MUL;
            ST_V_MUL:     n_state = ST_V_UPD;
            ST_V_UPD:     n_state = i_decay_enable ? ST_UD_MUL : ST_ELEM_WR;
            ST_UD_MUL:    n_state = ST_UD_UPD;
            ST_UD_UPD:    n_state = ST_VD_MUL;
            ST_VD_MUL:    n_state = ST_VD_UPD;
            ST_VD_UPD:    n_state = ST_ELEM_WR;
            ST_ELEM_WR: begin
                n_cnt   = cnt_inc;
                n_state = cnt_last ? ST_BIAS_G : ST_U_MUL;
            end
            ST_BIAS_G:    n_state = i_decay_enable ? ST_UBD_MUL : ST_BIAS_WR;
            ST_UBD_MUL:   n_state = ST_UBD_UPD;
            ST_UBD_UPD:   n_state = ST_IBD_MUL;
            ST_IBD_MUL:   n_state = ST_IBD_UPD;
            ST_IBD_UPD:   n_state = ST_BIAS_WR;
            ST_BIAS_WR:   n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.mul_sel = MUL_UV;
        o_cmd.out_sel = OUT_ZERO;
        o_rd_elem  = r_cnt[EW-1:0];
        o_wr_elem  = r_cnt[EW-1:0];
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_DISPATCH:  o_cmd.acc_clr = 1'b1;
            ST_WRITE:     o_cmd.op_we   = 1'b1;
            ST_READ:      ;
            ST_DOT: begin
                o_cmd.mul_sel   = MUL_UV;
                o_cmd.dot_issue = (32'(r_cnt) < FACTORS);
            end
            ST_RESID:     o_cmd.res_en = 1'b1;
            ST_MUL_GAIN:  o_cmd.mul_sel = MUL_LR_E;
            ST_LOAD_GAIN: begin
                o_cmd.g_en    = 1'b1;
                o_cmd.mul_sel = MUL_LR_FD;
            end
            ST_LOAD_S: begin
                o_cmd.s_en    = 1'b1;
                o_cmd.mul_sel = MUL_LR_BD;
            end
            ST_LOAD_T:    o_cmd.t_en = 1'b1;
            ST_U_MUL: begin
                o_cmd.uv_load = 1'b1;
                o_cmd.mul_sel = MUL_G_VRAM;
            end
            ST_U_UPD:     o_cmd.u_upd = 1'b1;
            ST_V_MUL:     o_cmd.mul_sel = MUL_G_U;
            ST_V_UPD:     o_cmd.v_upd = 1'b1;
            ST_UD_MUL:    o_cmd.mul_sel = MUL_S_U;
            ST_UD_UPD:    o_cmd.u_upd = 1'b1;
            ST_VD_MUL:    o_cmd.mul_sel = MUL_S_V;
            ST_VD_UPD:    o_cmd.v_upd = 1'b1;
            ST_ELEM_WR: begin
                o_cmd.fac_we = 1'b1;
                o_rd_elem    = cnt_inc[EW-1:0];
            end
            ST_BIAS_G:    o_cmd.bias_g = 1'b1;
            ST_UBD_MUL:   o_cmd.mul_sel = MUL_T_UB;
            ST_UBD_UPD:   o_cmd.ub_upd = 1'b1;
            ST_IBD_MUL:   o_cmd.mul_sel = MUL_T_IB;
            ST_IBD_UPD:   o_cmd.ib_upd = 1'b1;
            ST_BIAS_WR:   o_cmd.bias_we = 1'b1;
            ST_DONE: begin
                o_cmd.out_load = out_free;
                if (i_status.target_ok && i_status.is_train) begin
                    o_cmd.out_sel = OUT_RESID;
                end else if (i_status.target_ok && i_status.is_read) begin
                    o_cmd.out_sel = OUT_READ;
                end else begin
                    o_cmd.out_sel = OUT_ZERO;
                end
            end
            default:      ;
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule

[design/mfsgd_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the SGD block: factor and bias memories, shared multiplier,
// accumulator, update registers and the result register. Uses mfsgd_pkg, mfsgd_ram.
module mfsgd_datapath #(
    parameter int FACTORS = 16,
    parameter int USERS   = 1024,
    parameter int ITEMS   = 1024,
    parameter int EW = (FACTORS > 1) ? $clog2(FACTORS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mfsgd_pkg::t_in_item   i_item,
    input  mfsgd_pkg::t_cfg       i_cfg,
    input  mfsgd_pkg::t_dp_cmd    i_cmd,
    input  logic [EW-1:0]         i_rd_elem,
    input  logic [EW-1:0]         i_wr_elem,
    output mfsgd_pkg::t_dp_status o_status,
    output mfsgd_pkg::t_out_item  o_result
);
    import mfsgd_pkg::*;

    localparam int UFD = USERS * FACTORS;
    localparam int IFD = ITEMS * FACTORS;
    localparam int UFA = $clog2(UFD);
    localparam int IFA = $clog2(IFD);
    localparam int UBA = $clog2(USERS);
    localparam int IBA = $clog2(ITEMS);

    t_in_item           r_item;
    logic               r_dv1, r_dv2;
    t_wide              r_acc;
    logic signed [65:0] r_prod;
    logic signed [31:0] r_e;
    logic signed [33:0] r_g, r_s, r_t;
    logic signed [31:0] r_u, r_v, r_ub, r_ib;
    t_out_item          r_out, n_out;

    logic signed [31:0] uf_rdata, if_rdata, ub_rdata, ib_rdata;
    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;
    t_wide              prod_rnd;
    t_wide              bias_sum;

    logic [8:0]         f_ext;
    logic [EW-1:0]      op_elem;
    logic [EW-1:0]      rd_elem, wr_elem;
    logic               f_is_factor, f_is_bias, user_ok, item_ok;

    logic               uf_we, if_we, ub_we, ib_we;
    logic [31:0]        uf_wdata, if_wdata, ub_wdata, ib_wdata;
    logic [UFA-1:0]     uf_waddr, uf_raddr;
    logic [IFA-1:0]     if_waddr, if_raddr;
    logic [UBA-1:0]     ub_addr;
    logic [IBA-1:0]     ib_addr;

    // Decode of the held item
    assign f_ext       = 9'(r_item.factor_index);
    assign op_elem     = f_ext[EW-1:0];
    assign f_is_factor = (32'(r_item.factor_index) < FACTORS);
    assign f_is_bias   = (32'(r_item.factor_index) == FACTORS);
    assign user_ok     = (32'(r_item.user_index) < USERS);
    assign item_ok     = (32'(r_item.item_index) < ITEMS);

    always_comb begin
        o_status = '0;
        case (r_item.opcode) inside
            OP_TRAIN: begin
                o_status.is_train  = 1'b1;
                o_status.target_ok = user_ok && item_ok;
            end
            OP_WRITE_USER, OP_READ_USER: begin
                o_status.is_write  = (r_item.opcode == OP_WRITE_USER);
                o_status.is_read   = (r_item.opcode == OP_READ_USER);
                o_status.target_ok = user_ok && (f_is_factor || f_is_bias);
            end
            OP_WRITE_ITEM, OP_READ_ITEM: begin
                o_status.is_write  = (r_item.opcode == OP_WRITE_ITEM);
                o_status.is_read   = (r_item.opcode == OP_READ_ITEM);
                o_status.target_ok = item_ok && (f_is_factor || f_is_bias);
            end
            default: o_status = '0;
        endcase
    end

    // Addressing: train steps through elements, single accesses use factor_index
    assign rd_elem = o_status.is_train ? i_rd_elem : op_elem;
    assign wr_elem = o_status.is_train ? i_wr_elem : op_elem;

    assign uf_raddr = UFA'(UFA'(r_item.user_index) * UFA'(FACTORS) + UFA'(rd_elem));
    assign uf_waddr = UFA'(UFA'(r_item.user_index) * UFA'(FACTORS) + UFA'(wr_elem));
    assign if_raddr = IFA'(IFA'(r_item.item_index) * IFA'(FACTORS) + IFA'(rd_elem));
    assign if_waddr = IFA'(IFA'(r_item.item_index) * IFA'(FACTORS) + IFA'(wr_elem));
    assign ub_addr  = UBA'(r_item.user_index);
    assign ib_addr  = IBA'(r_item.item_index);

    always_comb begin
        uf_we    = i_cmd.fac_we;
        if_we    = i_cmd.fac_we;
        ub_we    = i_cmd.bias_we;
        ib_we    = i_cmd.bias_we;
        uf_wdata = r_u;
        if_wdata = r_v;
        ub_wdata = r_ub;
        ib_wdata = r_ib;
        if (i_cmd.op_we) begin
            uf_we    = (r_item.opcode == OP_WRITE_USER) && f_is_factor;
            ub_we    = (r_item.opcode == OP_WRITE_USER) && f_is_bias;
            if_we    = (r_item.opcode == OP_WRITE_ITEM) && f_is_factor;
            ib_we    = (r_item.opcode == OP_WRITE_ITEM) && f_is_bias;
            uf_wdata = r_item.write_data;
            if_wdata = r_item.write_data;
            ub_wdata = r_item.write_data;
            ib_wdata = r_item.write_data;
        end
    end

    mfsgd_ram #(.WIDTH(32), .DEPTH(UFD)) u_user_factor (
        .i_clk  (i_clk),
        .i_we   (uf_we),
        .i_waddr(uf_waddr),
        .i_wdata(uf_wdata),
        .i_raddr(uf_raddr),
        .o_rdata(uf_rdata)
    );

    mfsgd_ram #(.WIDTH(32), .DEPTH(IFD)) u_item_factor (
        .i_clk  (i_clk),
        .i_we   (if_we),
        .i_waddr(if_waddr),
        .i_wdata(if_wdata),
        .i_raddr(if_raddr),
        .o_rdata(if_rdata)
    );

    mfsgd_ram #(.WIDTH(32), .DEPTH(USERS)) u_user_bias (
        .i_clk  (i_clk),
        .i_we   (ub_we),
        .i_waddr(ub_addr),
        .i_wdata(ub_wdata),
        .i_raddr(ub_addr),
        .o_rdata(ub_rdata)
    );

    mfsgd_ram #(.WIDTH(32), .DEPTH(ITEMS)) u_item_bias (
        .i_clk  (i_clk),
        .i_we   (ib_we),
        .i_waddr(ib_addr),
        .i_wdata(ib_wdata),
        .i_raddr(ib_addr),
        .o_rdata(ib_rdata)
    );

    // Shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_UV:     begin mul_a = 34'(uf_rdata);                 mul_b = if_rdata; end
            MUL_LR_E:   begin mul_a = $signed({18'd0, i_cfg.learn_rate}); mul_b = r_e; end
            MUL_LR_FD:  begin
                mul_a = $signed({18'd0, i_cfg.learn_rate});
                mul_b = $signed({16'd0, i_cfg.factor_decay});
            end
            MUL_LR_BD:  begin
                mul_a = $signed({18'd0, i_cfg.learn_rate});
                mul_b = $signed({16'd0, i_cfg.bias_decay});
            end
            MUL_G_VRAM: begin mul_a = r_g; mul_b = if_rdata; end
            MUL_G_U:    begin mul_a = r_g; mul_b = r_u;      end
            MUL_S_U:    begin mul_a = r_s; mul_b = r_u;      end
            MUL_S_V:    begin mul_a = r_s; mul_b = r_v;      end
            MUL_T_UB:   begin mul_a = r_t; mul_b = r_ub;     end
            MUL_T_IB:   begin mul_a = r_t; mul_b = r_ib;     end
            default:    begin mul_a = '0;  mul_b = '0;       end
        endcase
    end

    assign prod_rnd = rnd16(r_prod);
    assign bias_sum = i_cfg.bias_enable ? (WIDE_W'(ub_rdata) + WIDE_W'(ib_rdata)) : '0;

    // Result of the finished item
    always_comb begin
        n_out = '0;
        case (i_cmd.out_sel)
            OUT_RESID: n_out.residual = r_e;
            OUT_READ: begin
                if (r_item.opcode == OP_READ_USER) begin
                    n_out.read_data = f_is_bias ? ub_rdata : uf_rdata;
                end else begin
                    n_out.read_data = f_is_bias ? ib_rdata : if_rdata;
                end
            end
            default: ;
        endcase
    end

    // Control flags of the dot-product pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv1 <= 1'b0;
            r_dv2 <= 1'b0;
        end else begin
            r_dv1 <= i_cmd.dot_issue;
            r_dv2 <= r_dv1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_dv2) begin
            r_acc <= r_acc + prod_rnd;
        end
        if (i_cmd.res_en) begin
            r_e <= sat32(r_acc + bias_sum - WIDE_W'(r_item.rating_value));
        end
        if (i_cmd.g_en) begin
            r_g <= 34'(prod_rnd);
        end
        if (i_cmd.s_en) begin
            r_s <= 34'(prod_rnd);
        end
        if (i_cmd.t_en) begin
            r_t <= 34'(prod_rnd);
        end
        if (i_cmd.uv_load) begin
            r_u <= uf_rdata;
            r_v <= if_rdata;
        end
        if (i_cmd.u_upd) begin
            r_u <= sat32(WIDE_W'(r_u) - prod_rnd);
        end
        if (i_cmd.v_upd) begin
            r_v <= sat32(WIDE_W'(r_v) - prod_rnd);
        end
        if (i_cmd.bias_g) begin
            r_ub <= sat32(WIDE_W'(ub_rdata) - WIDE_W'(r_g));
            r_ib <= sat32(WIDE_W'(ib_rdata) - WIDE_W'(r_g));
        end
        if (i_cmd.ub_upd) begin
            r_ub <= sat32(WIDE_W'(r_ub) - prod_rnd);
        end
        if (i_cmd.ib_upd) begin
            r_ib <= sat32(WIDE_W'(r_ib) - prod_rnd);
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;
endmodule

[design/matrix_factorization_sgd_step.sv]
`timescale 1ns / 1ps
// Top level of the matrix factorization SGD block: configuration registers,
// sequencer and datapath. Uses mfsgd_pkg, mfsgd_ctrl, mfsgd_datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one operation
//   per item: train on a (user, item, rating) triple, write one table element,
//   or read one table element. Factor index FACTORS addresses the row bias.
//   Output channel (o_out_valid / i_out_stall / o_out_item) returns exactly one
//   item per operation: residual for train, read data for reads, else zeros.
//   The APB port sets learn_rate, decay weights and the enable bits; write it
//   only while the block is idle.
// Sequencing:
//   The dot product streams one element per cycle through the
//   single-port-read factor memories; the row update then runs each element
//   through the one shared multiplier, two products without decay, four with.
//   One item is in work at a time; o_in_stall is low only in the idle state.
// Reset: clears the sequencer and the configuration (learn_rate 655, others
//   zero). Table contents are not cleared; load them before reading.
// Output stall: the finished item waits in the output register; the next
//   input item is still taken and runs until its own result is ready.
module matrix_factorization_sgd_step #(
    parameter int FACTORS = 16,
    parameter int USERS   = 1024,
    parameter int ITEMS   = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  mfsgd_pkg::t_in_item                   i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output mfsgd_pkg::t_out_item                  o_out_item,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mfsgd_pkg::REG_ADDR_W-1:0]      paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import mfsgd_pkg::*;

    localparam int EW = (FACTORS > 1) ? $clog2(FACTORS) : 1;
    localparam int CW = $clog2(FACTORS + 2);

    t_cfg       r_cfg;
    t_dp_cmd    cmd;
    t_dp_status status;
    logic [EW-1:0] rd_elem, wr_elem;
    logic [2:0] reg_idx;
    logic       cfg_wr;

    // Configuration registers; word index in paddr[4:2]
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learn_rate   <= LEARN_RATE_RESET;
            r_cfg.factor_decay <= '0;
            r_cfg.bias_decay   <= '0;
            r_cfg.decay_enable <= 1'b0;
            r_cfg.bias_enable  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_LEARN_RATE:   r_cfg.learn_rate   <= pwdata[15:0];
                REG_FACTOR_DECAY: r_cfg.factor_decay <= pwdata[15:0];
                REG_BIAS_DECAY:   r_cfg.bias_decay   <= pwdata[15:0];
                REG_DECAY_ENABLE: r_cfg.decay_enable <= pwdata[0];
                REG_BIAS_ENABLE:  r_cfg.bias_enable  <= pwdata[0];
                default:          ;   // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LEARN_RATE:   prdata = {16'd0, r_cfg.learn_rate};
            REG_FACTOR_DECAY: prdata = {16'd0, r_cfg.factor_decay};
            REG_BIAS_DECAY:   prdata = {16'd0, r_cfg.bias_decay};
            REG_DECAY_ENABLE: prdata = {31'd0, r_cfg.decay_enable};
            REG_BIAS_ENABLE:  prdata = {31'd0, r_cfg.bias_enable};
            default:          prdata = '0;
        endcase
    end

    // Sequencer: owns both handshakes and steps the datapath
    mfsgd_ctrl #(.FACTORS(FACTORS), .EW(EW), .CW(CW)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_decay_enable(r_cfg.decay_enable),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_rd_elem     (rd_elem),
        .o_wr_elem     (wr_elem)
    );

    // Memories, multiplier and result register
    mfsgd_datapath #(
        .FACTORS(FACTORS),
        .USERS  (USERS),
        .ITEMS  (ITEMS),
        .EW     (EW)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in_item),
        .i_cfg    (r_cfg),
        .i_cmd    (cmd),
        .i_rd_elem(rd_elem),
        .i_wr_elem(wr_elem),
        .o_status (status),
        .o_result (o_out_item)
    );
endmodule
